// File: src/alarm_tbl_pkg.sv
// Package with the types, constants and helper functions of the alarm table.
package alarm_tbl_pkg;

  // Table geometry.
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int PTR_W     = $clog2(NUM_SLOTS + 1);
  localparam int CNT_W     = PTR_W;
  localparam int IDX_CMP_W = (PTR_W > 3) ? PTR_W : 3;
  localparam int SAT_W     = (CNT_W > 4) ? CNT_W : 4;
  localparam int MAX_COUNT_OUT = (NUM_SLOTS > 15) ? 15 : NUM_SLOTS;

  // Weekday masks selected by the repeat choice of an add.
  localparam logic [6:0] MASK_ONCE     = 7'h00;
  localparam logic [6:0] MASK_DAILY    = 7'h7F;
  localparam logic [6:0] MASK_WEEKDAYS = 7'h3E;
  localparam logic [6:0] MASK_WEEKEND  = 7'h41;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_ENABLE = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REP_ONCE     = 2'd0,
    REP_DAILY    = 2'd1,
    REP_WEEKDAYS = 2'd2,
    REP_WEEKEND  = 2'd3
  } repeat_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_RMW,
    FSM_SCAN,
    FSM_DONE
  } state_e;

  // One input transaction, unpacked.
  typedef struct packed {
    op_e        op;
    logic [2:0] slot_index;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    repeat_e    repeat_choice;
    logic       enable_value;
    logic [2:0] now_weekday;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
    logic       time_valid;
  } item_t;

  // One stored slot; the valid bit lives in flip-flops outside the memory.
  typedef struct packed {
    logic       enabled;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] mask;
  } slot_entry_t;

  // Memory port request from the controller.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    slot_entry_t       wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  // One result transaction.
  typedef struct packed {
    status_e    status;
    logic [2:0] slot;
    logic       fired;
    logic [3:0] active_count;
  } result_t;

  // Map a repeat choice to its weekday mask.
  function automatic logic [6:0] repeat_mask(repeat_e rep);
    logic [6:0] m;
    case (rep)
      REP_ONCE:     m = MASK_ONCE;
      REP_DAILY:    m = MASK_DAILY;
      REP_WEEKDAYS: m = MASK_WEEKDAYS;
      REP_WEEKEND:  m = MASK_WEEKEND;
      default:      m = MASK_ONCE;
    endcase
    return m;
  endfunction

  // True when a slot index addresses an existing slot.
  function automatic logic slot_in_range(logic [2:0] idx);
    return IDX_CMP_W'(idx) < IDX_CMP_W'(NUM_SLOTS);
  endfunction

  // Saturate the valid count to the four-bit output field.
  function automatic logic [3:0] sat_count(logic [CNT_W-1:0] cnt);
    logic [SAT_W-1:0] c;
    c = SAT_W'(cnt);
    return (c > SAT_W'(15)) ? 4'd15 : 4'(c);
  endfunction

endpackage

// File: src/alarm_tbl_ram.sv
// Slot memory: one write port and one registered read port.
module alarm_tbl_ram (
  input  logic                       clk_i,
  input  alarm_tbl_pkg::mem_req_t    req_i,
  output alarm_tbl_pkg::slot_entry_t rd_data_o
);

  alarm_tbl_pkg::slot_entry_t mem_q [alarm_tbl_pkg::NUM_SLOTS];
  alarm_tbl_pkg::slot_entry_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem_q[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/alarm_tbl_ctrl.sv
// Sequencer that executes one operation at a time against the slot memory.
module alarm_tbl_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  alarm_tbl_pkg::item_t       item_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output alarm_tbl_pkg::result_t     res_o,
  output alarm_tbl_pkg::mem_req_t    mem_req_o,
  input  alarm_tbl_pkg::slot_entry_t rd_data_i
);

  localparam int NS = alarm_tbl_pkg::NUM_SLOTS;
  localparam int SW = alarm_tbl_pkg::SLOT_W;
  localparam int PW = alarm_tbl_pkg::PTR_W;
  localparam int CW = alarm_tbl_pkg::CNT_W;

  alarm_tbl_pkg::state_e  state_q, state_d;
  alarm_tbl_pkg::item_t   item_q, item_d;
  alarm_tbl_pkg::result_t res_q, res_d;
  logic [NS-1:0]          valid_q, valid_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [PW-1:0]          rd_ptr_q, rd_ptr_d;
  logic [SW-1:0]          chk_ptr_q, chk_ptr_d;
  logic                   chk_vld_q, chk_vld_d;

  logic                   free_any;
  logic [SW-1:0]          free_idx;
  logic [SW-1:0]          sel_idx;
  logic                   sel_ok;
  logic                   tick_live;
  logic [7:0]             mask_ext;
  logic                   day_ok;
  logic                   hit;
  logic                   scan_end;

  // Lowest-numbered free slot for an add.
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign sel_idx   = SW'(item_q.slot_index);
  assign sel_ok    = alarm_tbl_pkg::slot_in_range(item_q.slot_index);
  assign tick_live = item_q.time_valid && (item_q.now_second == 6'd0);

  // Match check on the entry that the memory returned during the scan.
  assign mask_ext = {1'b0, rd_data_i.mask};
  assign day_ok   = (rd_data_i.mask == 7'd0) || mask_ext[item_q.now_weekday];
  assign hit      = chk_vld_q && valid_q[chk_ptr_q] && rd_data_i.enabled && day_ok &&
                    (rd_data_i.hour == item_q.now_hour) &&
                    (rd_data_i.minute == item_q.now_minute);
  assign scan_end = hit || (chk_vld_q && (chk_ptr_q == SW'(NS - 1)));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      alarm_tbl_pkg::FSM_IDLE: begin
        if (in_valid_i) state_d = alarm_tbl_pkg::FSM_EXEC;
      end
      alarm_tbl_pkg::FSM_EXEC: begin
        unique case (item_q.op)
          alarm_tbl_pkg::OP_ADD, alarm_tbl_pkg::OP_DELETE: begin
            state_d = alarm_tbl_pkg::FSM_DONE;
          end
          alarm_tbl_pkg::OP_ENABLE: begin
            state_d = sel_ok ? alarm_tbl_pkg::FSM_RMW : alarm_tbl_pkg::FSM_DONE;
          end
          alarm_tbl_pkg::OP_TICK: begin
            state_d = tick_live ? alarm_tbl_pkg::FSM_SCAN : alarm_tbl_pkg::FSM_DONE;
          end
        endcase
      end
      alarm_tbl_pkg::FSM_RMW: begin
        state_d = alarm_tbl_pkg::FSM_DONE;
      end
      alarm_tbl_pkg::FSM_SCAN: begin
        if (scan_end) state_d = alarm_tbl_pkg::FSM_DONE;
      end
      alarm_tbl_pkg::FSM_DONE: begin
        if (res_ready_i) state_d = alarm_tbl_pkg::FSM_IDLE;
      end
      default: state_d = alarm_tbl_pkg::FSM_IDLE;
    endcase
  end

  // Datapath and memory requests per state.
  always_comb begin
    item_d    = item_q;
    res_d     = res_q;
    valid_d   = valid_q;
    cnt_d     = cnt_q;
    rd_ptr_d  = rd_ptr_q;
    chk_ptr_d = chk_ptr_q;
    chk_vld_d = 1'b0;
    mem_req_o = '0;
    unique case (state_q)
      alarm_tbl_pkg::FSM_IDLE: begin
        if (in_valid_i) item_d = item_i;
      end
      alarm_tbl_pkg::FSM_EXEC: begin
        res_d.status = alarm_tbl_pkg::ST_OK;
        res_d.slot   = 3'd0;
        res_d.fired  = 1'b0;
        rd_ptr_d     = '0;
        unique case (item_q.op)
          alarm_tbl_pkg::OP_ADD: begin
            if (free_any) begin
              mem_req_o.we             = 1'b1;
              mem_req_o.waddr          = free_idx;
              mem_req_o.wdata.enabled  = 1'b1;
              mem_req_o.wdata.hour     = item_q.alarm_hour;
              mem_req_o.wdata.minute   = item_q.alarm_minute;
              mem_req_o.wdata.mask     = alarm_tbl_pkg::repeat_mask(item_q.repeat_choice);
              valid_d[free_idx]        = 1'b1;
              cnt_d                    = cnt_q + CW'(1);
              res_d.slot               = 3'(free_idx);
            end else begin
              res_d.status = alarm_tbl_pkg::ST_FULL;
            end
          end
          alarm_tbl_pkg::OP_DELETE: begin
            if (sel_ok && valid_q[sel_idx]) begin
              valid_d[sel_idx] = 1'b0;
              cnt_d            = cnt_q - CW'(1);
            end else begin
              res_d.status = alarm_tbl_pkg::ST_EMPTY;
            end
          end
          alarm_tbl_pkg::OP_ENABLE: begin
            // Fetch the entry; the enable bit is merged in the next cycle.
            if (sel_ok) begin
              mem_req_o.re    = 1'b1;
              mem_req_o.raddr = sel_idx;
            end
          end
          alarm_tbl_pkg::OP_TICK: begin
          end
        endcase
        res_d.active_count = alarm_tbl_pkg::sat_count(cnt_d);
      end
      alarm_tbl_pkg::FSM_RMW: begin
        mem_req_o.we            = 1'b1;
        mem_req_o.waddr         = sel_idx;
        mem_req_o.wdata         = rd_data_i;
        mem_req_o.wdata.enabled = item_q.enable_value;
      end
      alarm_tbl_pkg::FSM_SCAN: begin
        // Issue the next read while checking the entry read last cycle.
        if (!scan_end && (rd_ptr_q < PW'(NS))) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = SW'(rd_ptr_q);
          rd_ptr_d        = rd_ptr_q + PW'(1);
          chk_ptr_d       = SW'(rd_ptr_q);
          chk_vld_d       = 1'b1;
        end
        if (hit) begin
          res_d.fired = 1'b1;
          res_d.slot  = 3'(chk_ptr_q);
          // A one-shot alarm disables itself once it has fired.
          if (rd_data_i.mask == 7'd0) begin
            mem_req_o.we            = 1'b1;
            mem_req_o.waddr         = chk_ptr_q;
            mem_req_o.wdata         = rd_data_i;
            mem_req_o.wdata.enabled = 1'b0;
          end
        end
      end
      alarm_tbl_pkg::FSM_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= alarm_tbl_pkg::FSM_IDLE;
      valid_q   <= '0;
      cnt_q     <= '0;
      rd_ptr_q  <= '0;
      chk_ptr_q <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      cnt_q     <= cnt_d;
      rd_ptr_q  <= rd_ptr_d;
      chk_ptr_q <= chk_ptr_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  assign in_ready_o  = (state_q == alarm_tbl_pkg::FSM_IDLE);
  assign res_valid_o = (state_q == alarm_tbl_pkg::FSM_DONE);
  assign res_o       = res_q;

endmodule

// File: src/multi_slot_weekday_alarm_table.sv
// Top level of the weekday alarm table with stream ports and an output register.
//
// Each input transaction carries one operation (add, delete, set-enable or time
// tick) and yields exactly one result transaction. Operations run one at a time
// in a sequencer around a single-port-write, registered-read slot memory; slot
// valid bits are flip-flops cleared by reset. Add and delete run in the execute
// state, set-enable reads the entry and then writes it back, and a live tick
// scans the slots, with the memory returning one slot per cycle, until a hit or
// the last slot. A result waiting in the output register does not keep the next
// transaction from being accepted.
module multi_slot_weekday_alarm_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // slot_index[2:0], alarm_hour[7:3], alarm_minute[13:8], repeat_choice[15:14],
  // enable_value[16], now_weekday[19:17], now_hour[24:20], now_minute[30:25],
  // now_second[36:31], time_valid[37], zero[39:38]
  input  logic [39:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], result_slot[4:2], fired[5], active_count[9:6], zero[15:10]
  output logic [15:0] m_axis_tdata
);

  alarm_tbl_pkg::item_t       item;
  alarm_tbl_pkg::result_t     res;
  alarm_tbl_pkg::mem_req_t    mem_req;
  alarm_tbl_pkg::slot_entry_t rd_data;
  logic                       res_valid;
  logic                       res_ready;
  logic                       out_valid_q, out_valid_d;
  logic [15:0]                out_data_q, out_data_d;

  // Unpack the input transaction.
  always_comb begin
    item.op            = alarm_tbl_pkg::op_e'(s_axis_tuser[1:0]);
    item.slot_index    = s_axis_tdata[2:0];
    item.alarm_hour    = s_axis_tdata[7:3];
    item.alarm_minute  = s_axis_tdata[13:8];
    item.repeat_choice = alarm_tbl_pkg::repeat_e'(s_axis_tdata[15:14]);
    item.enable_value  = s_axis_tdata[16];
    item.now_weekday   = s_axis_tdata[19:17];
    item.now_hour      = s_axis_tdata[24:20];
    item.now_minute    = s_axis_tdata[30:25];
    item.now_second    = s_axis_tdata[36:31];
    item.time_valid    = s_axis_tdata[37];
  end

  alarm_tbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data)
  );

  alarm_tbl_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  // Output register: loads when empty or when its transaction completes.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_data_d = {6'd0, res.active_count, res.fired, res.slot, res.status};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// File: src/alarm_tbl_chk.sv
// Port-level checker for the alarm table, bound to the top level.
module alarm_tbl_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // A stalled result holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The reported count never exceeds the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[9:6] <= 4'(alarm_tbl_pkg::MAX_COUNT_OUT))
    else $error("active count above table size");

  // A fired alarm always reports status ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[1:0] == alarm_tbl_pkg::ST_OK)
    else $error("fired with error status");

  // An error status carries slot zero and no fire.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[1:0] != alarm_tbl_pkg::ST_OK)
      |-> (m_axis_tdata[4:2] == 3'd0) && !m_axis_tdata[5])
    else $error("error status with slot or fire");

  // The input is not accepted in the cycle right after an accepted transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

endmodule

bind multi_slot_weekday_alarm_table alarm_tbl_chk u_alarm_tbl_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
